// ===== src/iopr_pkg.sv =====
// Shared definitions for the I/O port range decoder.
// Holds operation codes, field widths and the table entry record.
// No dependencies.
package iopr_pkg;

   localparam int PORT_W  = 16;
   localparam int LOW_W   = 16;
   localparam int HIGH_W  = 17;
   localparam int ENTRY_W = 7;

   localparam logic [1:0] OP_REGISTER   = 2'd0;
   localparam logic [1:0] OP_UNREGISTER = 2'd1;
   localparam logic [1:0] OP_LOOKUP     = 2'd2;

   // One table entry as it is kept in the range memory.
   typedef struct packed {
      logic [HIGH_W-1:0] high;
      logic [LOW_W-1:0]  low;
   } range_type;

   localparam int RANGE_W = $bits(range_type);

endpackage

// ===== src/iopr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the range table of the I/O port range decoder; no dependencies.
module iopr_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/io_port_range_decoder.sv =====
// Top level of the I/O port range decoder: sequencer, scan compare and result register.
// Depends on iopr_pkg and iopr_ram.
// An operation stops its scan at the first matching entry; a miss scans every entry, and an
// unknown operation goes straight to the result.
// Only one operation is handled at a time; its scan reads one table entry per cycle through
// the single read port of the range memory.
// Reset: the state machine sweeps the memory and writes every entry to zero, one entry a
// cycle, so req_tready stays low until the sweep is finished.
module io_port_range_decoder #(
   parameter int ENTRIES = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // port [15:0], range_low [31:16], range_high [48:32]
   input  logic [1:0]  req_tuser,   // func [1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // entry [6:0]
   output logic        rsp_tuser    // status [0]
);

   localparam int IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   // Sequencer states.
   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   // Latched request.
   logic [1:0]                    op_ff, op_in;
   logic [iopr_pkg::PORT_W-1:0]   port_ff, port_in;
   logic [iopr_pkg::LOW_W-1:0]    low_ff, low_in;
   logic [iopr_pkg::HIGH_W-1:0]   high_ff, high_in;

   // Address counter shared by the clearing sweep and the scan.
   logic [IW-1:0] addr_ff, addr_in;
   logic          issue_done_ff, issue_done_in;

   // Read pipeline: the entry returned this cycle and where it came from.
   logic          data_valid_ff, data_valid_in;
   logic [IW-1:0] data_idx_ff, data_idx_in;
   logic          data_last_ff, data_last_in;

   // Scan outcome.
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [iopr_pkg::ENTRY_W-1:0] rsp_entry_ff, rsp_entry_in;

   logic                         req_xfer;
   logic                         rsp_load;
   logic                         entry_match;
   iopr_pkg::range_type          rd_entry;
   iopr_pkg::range_type          wr_entry;
   logic [iopr_pkg::RANGE_W-1:0] rd_word;
   logic                         ram_wr_en;
   logic [IW-1:0]                ram_wr_addr;
   logic                         ram_rd_en;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // The result register frees up when it is empty or its transfer completes this cycle.
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   assign rd_entry = iopr_pkg::range_type'(rd_word);

   // Per-operation match test on the entry that the memory returns.
   always_comb begin
      unique case (op_ff)
         iopr_pkg::OP_REGISTER:
            entry_match = (rd_entry.high == '0);
         iopr_pkg::OP_UNREGISTER:
            entry_match = (rd_entry.high == high_ff) && (rd_entry.low == low_ff);
         iopr_pkg::OP_LOOKUP:
            entry_match = ({1'b0, port_ff} < rd_entry.high) && (port_ff >= rd_entry.low);
         default:
            entry_match = 1'b0;
      endcase
   end

   // Memory ports. Reads happen only while scanning, writes only in the clearing sweep and
   // in the finish state, and a new request is taken only after the write, so accesses to
   // one entry never overlap and no forwarding is needed.
   always_comb begin
      ram_rd_en   = (state_ff == S_SCAN) && !issue_done_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      wr_entry    = '0;
      if (state_ff == S_CLEAR) begin
         ram_wr_en = 1'b1;
      end else if (state_ff == S_FINISH && hit_ff) begin
         ram_wr_addr = hit_idx_ff;
         if (op_ff == iopr_pkg::OP_REGISTER) begin
            ram_wr_en     = 1'b1;
            wr_entry.low  = low_ff;
            wr_entry.high = high_ff;
         end else if (op_ff == iopr_pkg::OP_UNREGISTER) begin
            ram_wr_en = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      port_in       = port_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      data_valid_in = ram_rd_en;
      data_idx_in   = addr_ff;
      data_last_in  = (addr_ff == LAST_IDX);
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;

      if (ram_rd_en) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               op_in         = req_tuser;
               port_in       = req_tdata[15:0];
               low_in        = req_tdata[31:16];
               high_in       = req_tdata[48:32];
               addr_in       = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               hit_idx_in    = '0;
               // An unknown operation has nothing to scan for.
               state_in      = (req_tuser == iopr_pkg::OP_REGISTER ||
                                req_tuser == iopr_pkg::OP_UNREGISTER ||
                                req_tuser == iopr_pkg::OP_LOOKUP) ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (data_valid_ff) begin
               if (entry_match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = data_idx_ff;
                  state_in   = S_FINISH;
               end else if (data_last_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = !hit_ff;
               rsp_entry_in  = hit_ff ? iopr_pkg::ENTRY_W'(hit_idx_ff) : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         data_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_done_ff <= issue_done_in;
         data_valid_ff <= data_valid_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      port_ff       <= port_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      data_idx_ff   <= data_idx_in;
      data_last_ff  <= data_last_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   iopr_ram #(
      .WIDTH (iopr_pkg::RANGE_W),
      .DEPTH (ENTRIES)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_entry_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The memory is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(ram_wr_en && ram_rd_en))
      else $error("range memory read and written in the same cycle");

   // A result is loaded only when the previous one has gone or is leaving.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // A failed operation reports entry zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_entry_ff == '0))
      else $error("failure reported with a nonzero entry");

   // Returned memory data is only seen while an operation is in progress.
   assert property (@(posedge clock) disable iff (reset)
      data_valid_ff |-> (state_ff == S_SCAN || state_ff == S_FINISH))
      else $error("read data outside an operation");

   // An accepted request starts a scan or goes straight to the result.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_SCAN || state_ff == S_FINISH))
      else $error("request transfer did not start an operation");

endmodule
